// File: design/atc_pkg.sv
// Shared types and constants for the affine transform composer.
// Holds the number format, the payload structs, the command classes and the CORDIC tables.
// No dependencies.
package atc_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  localparam word_t ONE = word_t'(64'sd1 <<< FRAC_BITS);
  localparam word_t WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  // input op codes
  localparam logic [2:0] OP_SCALE     = 3'd0;
  localparam logic [2:0] OP_ROT_X     = 3'd1;
  localparam logic [2:0] OP_ROT_Y     = 3'd2;
  localparam logic [2:0] OP_ROT_Z     = 3'd3;
  localparam logic [2:0] OP_TRANSLATE = 3'd4;
  localparam logic [2:0] OP_POINT     = 3'd5;
  localparam logic [2:0] OP_NORMAL    = 3'd6;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] angle_deg;
  } atc_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } atc_out_t;

  typedef enum logic [2:0] {
    CMD_SCALE,
    CMD_ROT_X,
    CMD_ROT_Y,
    CMD_ROT_Z,
    CMD_TRANSLATE,
    CMD_POINT,
    CMD_NORMAL
  } atc_cmd_e;

  typedef struct packed {
    atc_cmd_e cmd;
    word_t    vx;
    word_t    vy;
    word_t    vz;
    word_t    angle;
  } atc_cmd_t;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MAC,
    ST_COMMIT,
    ST_OUT
  } atc_state_e;

  typedef enum logic [1:0] {
    RUN_FULL,
    RUN_ROT,
    RUN_VEC
  } atc_run_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_REDUCE,
    CS_QUAD,
    CS_ROTATE,
    CS_FINISH
  } atc_cordic_e;

  // CORDIC constants
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int ANGLE_W      = 39;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam longint unsigned NANO_ONE = 64'd1000000000;

  // atan(2^-i) in degrees, scaled by 1e9
  localparam longint unsigned ATAN_NANO [CORDIC_STEPS] = '{
    64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
    64'd3576334375, 64'd1789910608, 64'd895173710, 64'd447614171,
    64'd223810500, 64'd111905677, 64'd55952892, 64'd27976453,
    64'd13988227, 64'd6994114, 64'd3497057, 64'd1748528,
    64'd874264, 64'd437132, 64'd218566, 64'd109283,
    64'd54642, 64'd27321, 64'd13660, 64'd6830,
    64'd3415, 64'd1708, 64'd854, 64'd427,
    64'd213, 64'd107
  };

  // angle reduction, all at FRAC_BITS fraction bits
  localparam int RED_W = 34;
  localparam logic [RED_W-1:0] FULL_TURN   = RED_W'(64'd360 << FRAC_BITS);
  localparam logic [RED_W-1:0] TURN_OFFSET = RED_W'((64'd360 << FRAC_BITS) * 64'd92);
  localparam int RED_STEPS = 9;
  localparam int REM_W = 25;
  localparam logic [REM_W-1:0] QUARTER = REM_W'(64'd90 << FRAC_BITS);

endpackage

// File: design/atc_front.sv
// Front end of the affine transform composer: accepts input transactions,
// classifies the op and queues commands for the back end. Uses atc_pkg.
module atc_front import atc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  atc_in_t  in_data_i,
  output logic     cmd_valid_o,
  output atc_cmd_t cmd_o,
  input  logic     cmd_take_i
);

  atc_cmd_t               mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_q, rd_q;
  logic [CMD_PTR_W:0]     cnt_q;
  logic                   acc, keep, take;
  atc_cmd_t               item;

  assign full_o      = (cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign acc         = push_i && !full_o;
  assign take        = cmd_take_i && cmd_valid_o;

  always_comb begin
    item.vx    = in_data_i.coord_x;
    item.vy    = in_data_i.coord_y;
    item.vz    = in_data_i.coord_z;
    item.angle = in_data_i.angle_deg;
    item.cmd   = CMD_SCALE;
    keep       = 1'b1;
    case (in_data_i.op)
      OP_SCALE:     item.cmd = CMD_SCALE;
      OP_ROT_X:     item.cmd = CMD_ROT_X;
      OP_ROT_Y:     item.cmd = CMD_ROT_Y;
      OP_ROT_Z:     item.cmd = CMD_ROT_Z;
      OP_TRANSLATE: item.cmd = CMD_TRANSLATE;
      OP_POINT:     item.cmd = CMD_POINT;
      OP_NORMAL:    item.cmd = CMD_NORMAL;
      default:      keep = 1'b0; // undefined op: drop
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc && keep) begin
      mem_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (acc && keep) wr_q <= wr_q + 1'b1;
      if (take) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (CMD_PTR_W+1)'(acc && keep) - (CMD_PTR_W+1)'(take);
    end
  end

endmodule

// File: design/atc_cordic.sv
// Iterative sine/cosine unit: reduces the angle modulo 360 degrees one
// compare-subtract a cycle, then runs 30 CORDIC rotation steps. Uses atc_pkg.
module atc_cordic import atc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t angle_i,
  output logic  done_o,
  output word_t sin_o,
  output word_t cos_o
);

  atc_cordic_e state_q, state_d;
  logic [RED_W-1:0]          red_q;
  logic [3:0]                cnt_q;
  logic [4:0]                step_q;
  logic [1:0]                quad_q;
  logic signed [CORDIC_W-1:0] x_q, y_q;
  logic signed [ANGLE_W-1:0]  z_q;
  logic [ANGLE_W-1:0]         atan_w [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
    localparam longint unsigned Nano = ATAN_NANO[g];
    localparam longint unsigned Val  = ((Nano / NANO_ONE) << CORDIC_FRAC) +
                                       (((Nano % NANO_ONE) << CORDIC_FRAC) / NANO_ONE);
    assign atan_w[g] = ANGLE_W'(Val);
  end

  logic [RED_W-1:0]          cand;
  logic [REM_W-1:0]          r25, rem;
  logic [1:0]                quad;
  logic signed [CORDIC_W-1:0] dx, dy, c_raw, s_raw;
  logic signed [CORDIC_W:0]   c_rnd, s_rnd;
  logic signed [ANGLE_W-1:0]  at;

  assign cand = FULL_TURN << cnt_q;
  assign r25  = red_q[REM_W-1:0];
  assign dx   = y_q >>> step_q;
  assign dy   = x_q >>> step_q;
  assign at   = signed'(atan_w[step_q]);

  always_comb begin
    if (r25 >= REM_W'(3) * QUARTER) begin
      quad = 2'd3; rem = r25 - REM_W'(3) * QUARTER;
    end else if (r25 >= REM_W'(2) * QUARTER) begin
      quad = 2'd2; rem = r25 - REM_W'(2) * QUARTER;
    end else if (r25 >= QUARTER) begin
      quad = 2'd1; rem = r25 - QUARTER;
    end else begin
      quad = 2'd0; rem = r25;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE:   if (start_i) state_d = CS_REDUCE;
      CS_REDUCE: if (cnt_q == '0) state_d = CS_QUAD;
      CS_QUAD:   state_d = CS_ROTATE;
      CS_ROTATE: if (step_q == 5'(CORDIC_STEPS - 1)) state_d = CS_FINISH;
      CS_FINISH: state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  // quadrant map, then round to FRAC_BITS
  always_comb begin
    case (quad_q)
      2'd0:    begin c_raw = x_q;  s_raw = y_q;  end
      2'd1:    begin c_raw = -y_q; s_raw = x_q;  end
      2'd2:    begin c_raw = -x_q; s_raw = -y_q; end
      default: begin c_raw = y_q;  s_raw = -x_q; end
    endcase
    c_rnd  = ((CORDIC_W+1)'(c_raw) + (CORDIC_W+1)'(1 << (CORDIC_FRAC - FRAC_BITS - 1)))
             >>> (CORDIC_FRAC - FRAC_BITS);
    s_rnd  = ((CORDIC_W+1)'(s_raw) + (CORDIC_W+1)'(1 << (CORDIC_FRAC - FRAC_BITS - 1)))
             >>> (CORDIC_FRAC - FRAC_BITS);
    cos_o  = WORD_WIDTH'(c_rnd);
    sin_o  = WORD_WIDTH'(s_rnd);
    done_o = (state_q == CS_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        red_q <= {{(RED_W-WORD_WIDTH){angle_i[WORD_WIDTH-1]}}, angle_i} + TURN_OFFSET;
        cnt_q <= 4'(RED_STEPS - 1);
      end
      CS_REDUCE: begin
        if (red_q >= cand) red_q <= red_q - cand;
        cnt_q <= cnt_q - 1'b1;
      end
      CS_QUAD: begin
        quad_q <= quad;
        z_q    <= signed'(ANGLE_W'(rem)) <<< (CORDIC_FRAC - FRAC_BITS);
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        step_q <= '0;
      end
      CS_ROTATE: begin
        if (z_q >= 0) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
        end
        step_q <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: design/atc_back.sv
// Back end of the affine transform composer: holds both matrices and runs
// composes and vector transforms on one shared multiply-accumulate pipe. Uses atc_pkg.
module atc_back import atc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  atc_cmd_t cmd_i,
  output logic     cmd_take_o,
  output logic     trig_start_o,
  output word_t    trig_angle_o,
  input  logic     trig_done_i,
  input  word_t    trig_sin_i,
  input  word_t    trig_cos_i,
  output logic     empty_o,
  input  logic     pop_i,
  output atc_out_t out_data_o
);

  atc_state_e state_q, state_d;
  atc_run_e   run_q;
  atc_cmd_t   cmd_q;
  word_t      sin_q, cos_q;
  word_t      m_q [3][4];
  word_t      r_q [3][3];
  word_t      t_q [3][4];
  word_t      res_q [3];
  logic       iss_q;
  logic [1:0] ii_q, jj_q, kk_q;
  // multiply stage
  logic       pv_q, neg_q, first_q, last_q, final_q;
  logic [1:0] di_q, dj_q;
  logic [63:0] prod_q;
  word_t      base_q, acc_q;
  atc_out_t   out_q;
  logic       out_valid_q;

  logic       take, start_run, commit, load_out, done_b;
  atc_run_e   next_run;
  word_t      vv [3];

  assign vv[0] = cmd_q.vx;
  assign vv[1] = cmd_q.vy;
  assign vv[2] = cmd_q.vz;

  function automatic word_t coef(atc_cmd_e cmd, word_t v0, word_t v1, word_t v2,
                                 word_t s, word_t c, logic [1:0] row, logic [1:0] col);
    word_t val;
    word_t vr;
    vr  = (row == 2'd0) ? v0 : ((row == 2'd1) ? v1 : v2);
    val = (row == col) ? ONE : '0;
    case (cmd)
      CMD_SCALE:     if (row == col) val = vr;
      CMD_TRANSLATE: if (col == 2'd3) val = vr;
      CMD_ROT_X: begin
        if (row == 2'd1 && col == 2'd1) val = c;
        if (row == 2'd1 && col == 2'd2) val = -s;
        if (row == 2'd2 && col == 2'd1) val = s;
        if (row == 2'd2 && col == 2'd2) val = c;
      end
      CMD_ROT_Y: begin
        if (row == 2'd0 && col == 2'd0) val = c;
        if (row == 2'd0 && col == 2'd2) val = s;
        if (row == 2'd2 && col == 2'd0) val = -s;
        if (row == 2'd2 && col == 2'd2) val = c;
      end
      CMD_ROT_Z: begin
        if (row == 2'd0 && col == 2'd0) val = c;
        if (row == 2'd0 && col == 2'd1) val = -s;
        if (row == 2'd1 && col == 2'd0) val = s;
        if (row == 2'd1 && col == 2'd1) val = c;
      end
      default: ;
    endcase
    return val;
  endfunction

  // issue: operand select and multiply
  word_t       op_a, op_b, base;
  logic [1:0]  jmax;
  logic        k_end, j_end, i_end;
  logic [31:0] mag_a, mag_b;

  always_comb begin
    base = '0;
    case (run_q)
      RUN_FULL: begin
        op_a = coef(cmd_q.cmd, vv[0], vv[1], vv[2], sin_q, cos_q, ii_q, kk_q);
        op_b = m_q[kk_q][jj_q];
        if (jj_q == 2'd3) base = coef(cmd_q.cmd, vv[0], vv[1], vv[2], sin_q, cos_q, ii_q, 2'd3);
        jmax = 2'd3;
      end
      RUN_ROT: begin
        op_a = coef(cmd_q.cmd, vv[0], vv[1], vv[2], sin_q, cos_q, ii_q, kk_q);
        op_b = r_q[kk_q][jj_q[1:0] == 2'd3 ? 2'd2 : jj_q];
        jmax = 2'd2;
      end
      default: begin
        op_b = vv[kk_q];
        if (cmd_q.cmd == CMD_POINT) begin
          op_a = m_q[ii_q][kk_q];
          base = m_q[ii_q][3];
        end else begin
          op_a = r_q[ii_q][kk_q];
        end
        jmax = 2'd0;
      end
    endcase
    mag_a = op_a[WORD_WIDTH-1] ? 32'(-op_a) : 32'(op_a);
    mag_b = op_b[WORD_WIDTH-1] ? 32'(-op_b) : 32'(op_b);
    k_end = (kk_q == 2'd2);
    j_end = (jj_q == jmax);
    i_end = (ii_q == 2'd2);
  end

  // accumulate: round, saturate, saturating add
  logic [64:0] rnd;
  logic [48:0] shv, lim;
  word_t       pw, addend;
  logic signed [WORD_WIDTH:0] sum;
  word_t       sum_sat;

  always_comb begin
    rnd = {1'b0, prod_q} + 65'(1 << (FRAC_BITS - 1));
    shv = rnd[64:FRAC_BITS];
    lim = neg_q ? 49'h80000000 : 49'h7fffffff;
    if (shv > lim) pw = neg_q ? WMIN : WMAX;
    else pw = neg_q ? -word_t'(shv[31:0]) : word_t'(shv[31:0]);
    addend = first_q ? base_q : acc_q;
    sum    = (WORD_WIDTH+1)'(addend) + (WORD_WIDTH+1)'(pw);
    if (sum[WORD_WIDTH] != sum[WORD_WIDTH-1]) sum_sat = sum[WORD_WIDTH] ? WMIN : WMAX;
    else sum_sat = sum[WORD_WIDTH-1:0];
    done_b = pv_q && last_q && final_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.cmd)
            CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z: state_d = ST_TRIG;
            default:                         state_d = ST_MAC;
          endcase
        end
      end
      ST_TRIG:   if (trig_done_i) state_d = ST_MAC;
      ST_MAC:    if (done_b) state_d = (run_q == RUN_VEC) ? ST_OUT : ST_COMMIT;
      ST_COMMIT: begin
        if (run_q == RUN_FULL && (cmd_q.cmd == CMD_ROT_X || cmd_q.cmd == CMD_ROT_Y ||
                                  cmd_q.cmd == CMD_ROT_Z)) state_d = ST_MAC;
        else state_d = ST_IDLE;
      end
      ST_OUT:    if (!out_valid_q || pop_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take         = 1'b0;
    trig_start_o = 1'b0;
    start_run    = 1'b0;
    commit       = 1'b0;
    load_out     = 1'b0;
    next_run     = run_q;
    case (state_q)
      ST_IDLE: begin
        take = cmd_valid_i;
        if (cmd_valid_i) begin
          case (cmd_i.cmd)
            CMD_ROT_X, CMD_ROT_Y, CMD_ROT_Z: trig_start_o = 1'b1;
            CMD_POINT, CMD_NORMAL: begin start_run = 1'b1; next_run = RUN_VEC; end
            default:               begin start_run = 1'b1; next_run = RUN_FULL; end
          endcase
        end
      end
      ST_TRIG: if (trig_done_i) begin start_run = 1'b1; next_run = RUN_FULL; end
      ST_COMMIT: begin
        commit = 1'b1;
        if (state_d == ST_MAC) begin start_run = 1'b1; next_run = RUN_ROT; end
      end
      ST_OUT: load_out = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  assign cmd_take_o   = take;
  assign trig_angle_o = cmd_i.angle;
  assign empty_o      = !out_valid_q;
  assign out_data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= RUN_FULL;
      iss_q       <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) m_q[i][j] <= (i == j) ? ONE : '0;
        for (int j = 0; j < 3; j++) r_q[i][j] <= (i == j) ? ONE : '0;
      end
    end else begin
      state_q <= state_d;
      run_q   <= next_run;
      pv_q    <= iss_q;
      if (start_run) begin
        iss_q <= 1'b1;
      end else if (iss_q && k_end && j_end && i_end) begin
        iss_q <= 1'b0;
      end
      if (commit) begin
        for (int i = 0; i < 3; i++) begin
          if (run_q == RUN_FULL) begin
            for (int j = 0; j < 4; j++) m_q[i][j] <= t_q[i][j];
          end else begin
            for (int j = 0; j < 3; j++) r_q[i][j] <= t_q[i][j];
          end
        end
      end
      out_valid_q <= load_out || (out_valid_q && !pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    if (state_q == ST_TRIG && trig_done_i) begin
      sin_q <= trig_sin_i;
      cos_q <= trig_cos_i;
    end
    // advance issue counters k, then j, then i
    if (start_run) begin
      ii_q <= '0; jj_q <= '0; kk_q <= '0;
    end else if (iss_q) begin
      if (!k_end) begin
        kk_q <= kk_q + 1'b1;
      end else begin
        kk_q <= '0;
        if (!j_end) begin
          jj_q <= jj_q + 1'b1;
        end else begin
          jj_q <= '0;
          ii_q <= ii_q + 1'b1;
        end
      end
    end
    prod_q  <= 64'(mag_a) * 64'(mag_b);
    neg_q   <= op_a[WORD_WIDTH-1] ^ op_b[WORD_WIDTH-1];
    first_q <= (kk_q == 2'd0);
    last_q  <= k_end;
    final_q <= k_end && j_end && i_end;
    di_q    <= ii_q;
    dj_q    <= jj_q;
    base_q  <= base;
    if (pv_q) begin
      acc_q <= sum_sat;
      if (last_q) begin
        if (run_q == RUN_VEC) res_q[di_q] <= sum_sat;
        else t_q[di_q][dj_q] <= sum_sat;
      end
    end
    if (load_out) begin
      out_q.out_x <= res_q[0];
      out_q.out_y <= res_q[1];
      out_q.out_z <= res_q[2];
    end
  end

endmodule

// File: design/affine_transform_composer_core.sv
// Top level of the affine transform composer: front queue, back end and sine/cosine unit.
// Uses atc_pkg, atc_front, atc_back and atc_cordic.
//
// Keeps a 3x4 affine matrix and a 3x3 rotation matrix, both identity after reset, in
// signed Q16.16. Scale, rotate and translate transactions pre-multiply the affine matrix
// (rotations also the rotation matrix); point and normal transactions return one result.
// Op 7 is dropped. A four-deep command queue lets input transactions arrive while the
// back end is busy, and one output register holds a result until it is popped. All
// products go through one 32x32 multiplier, one product per cycle, with a multiply
// register and an accumulate register behind it: a point or normal runs 9 products,
// drains the pipe and loads the output; a scale or translate runs 36 products, drains the
// pipe and commits; and a rotation first runs the iterative sine/cosine unit (9 reduction
// steps, 30 CORDIC steps and its quadrant and finish states) and then two matrix composes.
module affine_transform_composer_core import atc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  atc_in_t  in_data_i,
  output logic     empty_o,
  input  logic     pop_i,
  output atc_out_t out_data_o
);

  logic     cmd_valid, cmd_take;
  atc_cmd_t cmd;
  logic     trig_start, trig_done;
  word_t    trig_angle, trig_sin, trig_cos;

  atc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  atc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i (trig_angle),
    .done_o  (trig_done),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos)
  );

  atc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_take_o   (cmd_take),
    .trig_start_o (trig_start),
    .trig_angle_o (trig_angle),
    .trig_done_i  (trig_done),
    .trig_sin_i   (trig_sin),
    .trig_cos_i   (trig_cos),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_data_o   (out_data_o)
  );

endmodule
